/* rtl/ssmpf_pkg.sv */
// Package: shared constants, types and glyph table for the seven-segment PWM fader.
package ssmpf_pkg;

   localparam int NUM_DIGITS_DEF = 6;
   localparam int SEGS = 7;
   localparam int LVL_W = 7;
   localparam int CNT_W = 16;
   localparam int LEVEL_MAX = 100;
   localparam int FADE_MAX = 10;
   localparam logic [7:0] MASK_BLANK = 8'hFF;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_CHAR = 2'd1;
   localparam logic [1:0] MODE_RAW  = 2'd2;

   localparam logic [1:0] REG_PERIOD   = 2'd0;
   localparam logic [1:0] REG_GLOBAL   = 2'd1;
   localparam logic [1:0] REG_FADE_LVL = 2'd2;
   localparam logic [1:0] REG_FADE_INT = 2'd3;

   localparam int QDEPTH = 4;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      logic       is_tick;
      logic [2:0] pos;
      logic [7:0] mask;
   } cmd_type;

   typedef struct packed {
      logic [6:0] segs;
      logic [15:0] digs;
   } rsp_type;

   function automatic logic [7:0] glyph(input logic [7:0] ch_in);
      logic [7:0] ch;
      logic [7:0] g;
      ch = ch_in;
      if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'd32;
      case (ch)
         "0": g = 8'hC0; "1": g = 8'hF9; "2": g = 8'hA4; "3": g = 8'hB0;
         "4": g = 8'h99; "5": g = 8'h92; "6": g = 8'h82; "7": g = 8'hF8;
         "8": g = 8'h80; "9": g = 8'h90;
         "A": g = 8'h88; "B": g = 8'h83; "C": g = 8'hC6; "D": g = 8'hA1;
         "E": g = 8'h86; "F": g = 8'h8E; "G": g = 8'hC2; "H": g = 8'h89;
         "I": g = 8'hF9; "J": g = 8'hF1; "L": g = 8'hC7; "N": g = 8'hAB;
         "O": g = 8'hC0; "P": g = 8'h8C; "Q": g = 8'h98; "R": g = 8'hAF;
         "S": g = 8'h92; "T": g = 8'h87; "U": g = 8'hC1; "Y": g = 8'h91;
         "-": g = 8'hBF; "_": g = 8'hF7;
         default: g = MASK_BLANK;
      endcase
      return g;
   endfunction

   // Fade step per level: 100/(level*5), level 0 gives 100.
   function automatic logic [6:0] fade_step(input logic [3:0] lvl);
      logic [6:0] s;
      case (lvl)
         4'd0: s = 7'd100; 4'd1: s = 7'd20; 4'd2: s = 7'd10; 4'd3: s = 7'd6;
         4'd4: s = 7'd5;   4'd5: s = 7'd4;  4'd6: s = 7'd3;  4'd7: s = 7'd2;
         4'd8: s = 7'd2;   4'd9: s = 7'd2;  4'd10: s = 7'd2;
         default: s = 7'd2;
      endcase
      return s;
   endfunction

endpackage

/* rtl/seven_segment_mux_pwm_fader_unit.sv */
// Top level of the multiplexed seven-segment PWM fader.
//
//  channel  direction  handshake          transfer when
//  req_     in         req_push/req_full  req_push && !req_full
//  rsp_     out        rsp_empty/rsp_pop  rsp_pop && !rsp_empty
//  csr_     in         csr_write          csr_write
//
// After reset the back end clears all NUM_DIGITS*7 level entries (42) before it
// takes the first command; items wait in the front queue meanwhile.
// A set command waits in the queue until the back end takes it in IDLE. A tick
// runs the back end from IDLE to EMIT, walking every segment level (NUM_DIGITS*7)
// in FADE when the fade counter wraps, and computing the seven threshold products
// in THR_RD, THR_MUL and THR_DIV on the first tick of a digit slot.
// Reset is synchronous and active high. A tick waits until the previous result
// has been popped.
module seven_segment_mux_pwm_fader_unit #(
   parameter int NUM_DIGITS = ssmpf_pkg::NUM_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_position,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_raw_mask,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_segment_lines,
   output logic [5:0]  rsp_digit_enable,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   // Classified commands pass through a short queue from front to back.
   logic q_valid, q_take;
   ssmpf_pkg::cmd_type q_cmd;

   ssmpf_front #(.NUM_DIGITS(NUM_DIGITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_mode, .req_position,
      .req_char_code, .req_raw_mask, .q_valid, .q_cmd, .q_take
   );

   ssmpf_back #(.NUM_DIGITS(NUM_DIGITS)) u_back (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .q_valid, .q_cmd,
      .q_take, .rsp_empty, .rsp_pop, .rsp_segment_lines, .rsp_digit_enable
   );
endmodule

/* rtl/ssmpf_front.sv */
// Front end: accepts items, decodes glyphs and drops ignored commands.
module ssmpf_front #(
   parameter int NUM_DIGITS = ssmpf_pkg::NUM_DIGITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_mode,
   input  logic [2:0]          req_position,
   input  logic [7:0]          req_char_code,
   input  logic [7:0]          req_raw_mask,
   output logic                q_valid,
   output ssmpf_pkg::cmd_type  q_cmd,
   input  logic                q_take
);
   localparam int PW = $clog2(ssmpf_pkg::QDEPTH);

   ssmpf_pkg::cmd_type mem_ff [ssmpf_pkg::QDEPTH];
   logic [PW-1:0] wp_ff, rp_ff, wp_in, rp_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          acc, keep;
   ssmpf_pkg::cmd_type c;

   assign req_full = (cnt_ff == PW'(0) + (PW+1)'(ssmpf_pkg::QDEPTH));
   assign acc = req_push && !req_full;

   always_comb begin
      c.is_tick = (req_mode == ssmpf_pkg::MODE_TICK);
      c.pos = req_position;
      c.mask = (req_mode == ssmpf_pkg::MODE_CHAR) ? ssmpf_pkg::glyph(req_char_code)
                                                  : req_raw_mask;
      keep = c.is_tick ||
             (((req_mode == ssmpf_pkg::MODE_CHAR) || (req_mode == ssmpf_pkg::MODE_RAW)) &&
              ({1'b0, req_position} < 4'(NUM_DIGITS)));
   end

   assign q_valid = (cnt_ff != '0);
   assign q_cmd = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff + PW'(acc && keep);
      rp_in = rp_ff + PW'(q_take && q_valid);
      cnt_in = cnt_ff + (PW+1)'(acc && keep) - (PW+1)'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (acc && keep) mem_ff[wp_ff] <= c;
   end
endmodule

/* rtl/ssmpf_back.sv */
// Back end: fade walk, threshold computation and PWM output register.
module ssmpf_back #(
   parameter int NUM_DIGITS = ssmpf_pkg::NUM_DIGITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                q_valid,
   input  ssmpf_pkg::cmd_type  q_cmd,
   output logic                q_take,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [6:0]          rsp_segment_lines,
   output logic [5:0]          rsp_digit_enable
);
   localparam int NSEG = NUM_DIGITS * ssmpf_pkg::SEGS;
   localparam int SW = $clog2(NSEG + 1);
   localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   typedef enum logic [2:0] {CLR, IDLE, FADE, THR_RD, THR_MUL, THR_DIV, EMIT} st_type;
   st_type st_ff;

   logic [15:0] period_ff, interval_ff, slot_len_ff, slot_cnt_ff, fade_cnt_ff;
   logic [6:0]  glob_ff;
   logic [3:0]  flvl_ff;
   logic [7:0]  masks_ff [NUM_DIGITS];
   logic [6:0]  lvl_mem [NSEG];
   logic [6:0]  rd_ff;
   logic [15:0] thr_ff [ssmpf_pkg::SEGS];
   logic [DW-1:0] dig_ff;
   logic [DW-1:0] fdig_ff;
   logic [SW-1:0] idx_ff;
   logic [2:0]  seg_ff;
   logic [22:0] pg_ff;
   logic [29:0] prod_ff;
   logic        out_v_ff;
   logic [6:0]  out_seg_ff;
   logic [5:0]  out_dig_ff;
   logic [6:0]  step;
   logic [15:0] fc_in;

   assign rsp_empty = !out_v_ff;
   assign rsp_segment_lines = out_seg_ff;
   assign rsp_digit_enable = out_dig_ff;
   assign q_take = (st_ff == IDLE) && q_valid && (!q_cmd.is_tick || !out_v_ff);
   assign step = ssmpf_pkg::fade_step(flvl_ff);
   assign fc_in = fade_cnt_ff + 16'd1;

   // Fade walk entry: the digit and segment counters track the level index.
   logic [6:0]    cur, tgt, nx;
   always_comb begin
      cur = rd_ff;
      tgt = masks_ff[fdig_ff][seg_ff] ? 7'd0 : 7'(ssmpf_pkg::LEVEL_MAX);
      nx = cur;
      if (cur < tgt) nx = ({1'b0, cur} + {1'b0, step} > {1'b0, tgt}) ? tgt : cur + step;
      else if (cur > tgt) nx = ({1'b0, cur} > {1'b0, step} + {1'b0, tgt}) ? cur - step : tgt;
   end

   // Division by 10000 via reciprocal; exact for all products below 2^30.
   logic [63:0] qe;
   logic [29:0] q0;
   always_comb begin
      qe = 64'(prod_ff) * 64'd1759218605;   // 2^44/10000 rounded up
      q0 = 30'(qe >> 44);
   end

   logic [6:0] mask_o;
   always_comb begin
      mask_o = 7'h7F;
      for (int s = 0; s < ssmpf_pkg::SEGS; s++)
         if (slot_cnt_ff < thr_ff[s]) mask_o[s] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CLR;
         period_ff <= 16'd208;
         glob_ff <= 7'd100;
         flvl_ff <= 4'd5;
         interval_ff <= 16'd2000;
         for (int d = 0; d < NUM_DIGITS; d++) masks_ff[d] <= ssmpf_pkg::MASK_BLANK;
         for (int s = 0; s < ssmpf_pkg::SEGS; s++) thr_ff[s] <= '0;
         dig_ff <= (NUM_DIGITS > 1) ? DW'(1) : '0;
         fdig_ff <= '0;
         slot_cnt_ff <= '0;
         fade_cnt_ff <= '0;
         slot_len_ff <= 16'd208;
         out_v_ff <= 1'b0;
         idx_ff <= '0;
         seg_ff <= '0;
      end else begin
         if (rsp_pop && out_v_ff) out_v_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               ssmpf_pkg::REG_PERIOD: period_ff <= csr_data;
               ssmpf_pkg::REG_GLOBAL:
                  glob_ff <= (csr_data[6:0] > 7'd100) ? 7'd100 :
                             (csr_data[6:0] == 7'd0) ? 7'd1 : csr_data[6:0];
               ssmpf_pkg::REG_FADE_LVL:
                  flvl_ff <= (csr_data[3:0] > 4'(ssmpf_pkg::FADE_MAX)) ?
                             4'(ssmpf_pkg::FADE_MAX) : csr_data[3:0];
               ssmpf_pkg::REG_FADE_INT: interval_ff <= csr_data;
               default: ;
            endcase
         end
         case (st_ff)
            CLR: begin
               lvl_mem[idx_ff] <= '0;
               if (idx_ff == SW'(NSEG - 1)) begin
                  idx_ff <= '0;
                  st_ff <= IDLE;
               end else idx_ff <= idx_ff + SW'(1);
            end
            IDLE: if (q_take) begin
               if (!q_cmd.is_tick) begin
                  masks_ff[DW'(q_cmd.pos)] <= q_cmd.mask;
               end else begin
                  idx_ff <= '0;
                  seg_ff <= '0;
                  fdig_ff <= '0;
                  if (fc_in < ((interval_ff == '0) ? 16'd1 : interval_ff)) begin
                     fade_cnt_ff <= fc_in;
                     st_ff <= (slot_cnt_ff == '0) ? THR_RD : EMIT;
                  end else begin
                     fade_cnt_ff <= '0;
                     st_ff <= FADE;
                  end
                  if (slot_cnt_ff == '0) slot_len_ff <= (period_ff == '0) ? 16'd1 : period_ff;
                  rd_ff <= lvl_mem[0];
               end
            end
            FADE: begin
               lvl_mem[idx_ff] <= nx;
               if (idx_ff == SW'(NSEG - 1)) begin
                  idx_ff <= '0;
                  seg_ff <= '0;
                  fdig_ff <= '0;
                  st_ff <= (slot_cnt_ff == '0) ? THR_RD : EMIT;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
                  rd_ff <= lvl_mem[idx_ff + SW'(1)];
                  if (seg_ff == 3'(ssmpf_pkg::SEGS - 1)) begin
                     seg_ff <= '0;
                     fdig_ff <= fdig_ff + DW'(1);
                  end else seg_ff <= seg_ff + 3'd1;
               end
            end
            THR_RD: begin
               rd_ff <= lvl_mem[SW'(dig_ff) * SW'(ssmpf_pkg::SEGS) + SW'(seg_ff)];
               pg_ff <= 23'(slot_len_ff * glob_ff);
               st_ff <= THR_MUL;
            end
            THR_MUL: begin
               prod_ff <= 30'(pg_ff * rd_ff);
               st_ff <= THR_DIV;
            end
            THR_DIV: begin
               thr_ff[seg_ff] <= (q0 > 30'(slot_len_ff)) ? slot_len_ff : 16'(q0);
               if (seg_ff == 3'(ssmpf_pkg::SEGS - 1)) st_ff <= EMIT;
               else begin
                  seg_ff <= seg_ff + 3'd1;
                  st_ff <= THR_RD;
               end
            end
            EMIT: begin
               out_v_ff <= 1'b1;
               out_seg_ff <= mask_o;
               out_dig_ff <= 6'(16'(1) << dig_ff);
               if (slot_cnt_ff + 16'd1 >= slot_len_ff) begin
                  slot_cnt_ff <= '0;
                  dig_ff <= (32'(dig_ff) + 1 >= NUM_DIGITS) ? '0 : dig_ff + DW'(1);
               end else slot_cnt_ff <= slot_cnt_ff + 16'd1;
               st_ff <= IDLE;
            end
            default: st_ff <= IDLE;
         endcase
      end
   end
endmodule

/* rtl/ssmpf_checker.sv */
// Port-level checker for the seven-segment PWM fader, bound to the top level.
module ssmpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [6:0] rsp_segment_lines,
   input logic [5:0] rsp_digit_enable
);
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> $onehot(rsp_digit_enable)) else $error("digit enable not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_segment_lines)))
      else $error("result changed while stalled");
   a_rst: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result after reset");
endmodule

bind seven_segment_mux_pwm_fader_unit ssmpf_checker u_chk (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_segment_lines, .rsp_digit_enable
);

/* verif/tb_seven_segment_mux_pwm_fader_unit.sv */
// Testbench for the seven-segment PWM fader: random and directed items against a predictor.
`timescale 1ns / 1ps

module tb_seven_segment_mux_pwm_fader_unit;

   localparam int NDIG = 6;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] position;
      logic [7:0] char_code;
      logic [7:0] raw_mask;
   } cmd_item_type;

   typedef struct packed {
      logic [6:0] segment_lines;
      logic [5:0] digit_enable;
   } frame_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_mode;
   logic [2:0]  req_position;
   logic [7:0]  req_char_code;
   logic [7:0]  req_raw_mask;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [6:0]  rsp_segment_lines;
   logic [5:0]  rsp_digit_enable;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   seven_segment_mux_pwm_fader_unit dut (.*);

   // Clock with a 12 ns period.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Predictor state: the configuration and the display state, kept at the
   // block's own widths.
   logic [15:0] cfg_period;
   logic [6:0]  cfg_global;
   logic [3:0]  cfg_fade_lvl;
   logic [15:0] cfg_fade_int;
   logic [7:0]  mask_mem[NDIG];
   logic [6:0]  level_mem[NDIG][ssmpf_pkg::SEGS];
   logic [15:0] thresh[ssmpf_pkg::SEGS];
   logic [2:0]  cur_digit;
   logic [15:0] slot_cnt;
   logic [15:0] fade_cnt;
   logic [15:0] slot_length;

   cmd_item_type pending_cmds[$];
   frame_type    expected_frames[$];

   int mismatches = 0;
   int watchdog = 0;
   bit timed_out = 1'b0;
   bit stim_done;
   bit hold_sender;
   int burst_left = 0;
   int gap_left = 0;
   int pop_phase = 0;
   logic req_full_q;

   function automatic logic [7:0] char_to_mask(input logic [7:0] ch_in);
      logic [7:0] c;
      c = ch_in;
      if (c >= "a" && c <= "z") c = c - 8'd32;
      case (c)
         "0", "O": return 8'hC0;
         "1", "I": return 8'hF9;
         "2": return 8'hA4; "3": return 8'hB0; "4": return 8'h99;
         "5", "S": return 8'h92;
         "6": return 8'h82; "7": return 8'hF8; "8": return 8'h80;
         "9": return 8'h90; "A": return 8'h88; "B": return 8'h83;
         "C": return 8'hC6; "D": return 8'hA1; "E": return 8'h86;
         "F": return 8'h8E; "G": return 8'hC2; "H": return 8'h89;
         "J": return 8'hF1; "L": return 8'hC7; "N": return 8'hAB;
         "P": return 8'h8C; "Q": return 8'h98; "R": return 8'hAF;
         "T": return 8'h87; "U": return 8'hC1; "Y": return 8'h91;
         "-": return 8'hBF; "_": return 8'hF7;
         default: return 8'hFF;
      endcase
   endfunction

   task automatic predictor_reset();
      cfg_period = 16'd208;
      cfg_global = 7'd100;
      cfg_fade_lvl = 4'd5;
      cfg_fade_int = 16'd2000;
      for (int d = 0; d < NDIG; d++) begin
         mask_mem[d] = 8'hFF;
         for (int s = 0; s < ssmpf_pkg::SEGS; s++) level_mem[d][s] = '0;
      end
      for (int s = 0; s < ssmpf_pkg::SEGS; s++) thresh[s] = '0;
      cur_digit = 3'd1;
      slot_cnt = '0;
      fade_cnt = '0;
      slot_length = 16'd208;
   endtask

   task automatic predict_csr(input logic [1:0] idx, input logic [15:0] val);
      int v;
      v = val;
      case (idx)
         ssmpf_pkg::REG_PERIOD: cfg_period = val;
         ssmpf_pkg::REG_GLOBAL: begin
            v = v & 8'h7F;
            if (v > 100) v = 100;
            if (v < 1) v = 1;
            cfg_global = v[6:0];
         end
         ssmpf_pkg::REG_FADE_LVL: begin
            v = v & 4'hF;
            if (v > ssmpf_pkg::FADE_MAX) v = ssmpf_pkg::FADE_MAX;
            cfg_fade_lvl = v[3:0];
         end
         ssmpf_pkg::REG_FADE_INT: cfg_fade_int = val;
         default: ;
      endcase
   endtask

   // Advance the crossfade counter and walk all levels when it wraps.
   task automatic advance_fade();
      int interval, step, cur, tgt;
      interval = (cfg_fade_int == 0) ? 1 : cfg_fade_int;
      fade_cnt = fade_cnt + 16'd1;
      if (fade_cnt < interval) return;
      fade_cnt = '0;
      step = (cfg_fade_lvl == 0) ? ssmpf_pkg::LEVEL_MAX :
             ssmpf_pkg::LEVEL_MAX / (cfg_fade_lvl * 5);
      if (step < 1) step = 1;
      for (int d = 0; d < NDIG; d++)
         for (int s = 0; s < ssmpf_pkg::SEGS; s++) begin
            cur = level_mem[d][s];
            tgt = mask_mem[d][s] ? 0 : ssmpf_pkg::LEVEL_MAX;
            if (cur < tgt) level_mem[d][s] = 7'((cur + step > tgt) ? tgt : cur + step);
            else if (cur > tgt) level_mem[d][s] = 7'((cur > step + tgt) ? cur - step : tgt);
         end
   endtask

   // Work out the effect of one accepted item; ticks queue one display frame.
   task automatic predict_item(input cmd_item_type it);
      longint prod;
      int dig;
      frame_type f;
      if (it.mode == ssmpf_pkg::MODE_CHAR || it.mode == ssmpf_pkg::MODE_RAW) begin
         if (it.position < NDIG)
            mask_mem[it.position] = (it.mode == ssmpf_pkg::MODE_CHAR) ?
                                    char_to_mask(it.char_code) : it.raw_mask;
         return;
      end
      if (it.mode != ssmpf_pkg::MODE_TICK) return;
      advance_fade();
      dig = (cur_digit < NDIG) ? cur_digit : 0;
      if (slot_cnt == 0) begin
         slot_length = (cfg_period == 0) ? 16'd1 : cfg_period;
         for (int s = 0; s < ssmpf_pkg::SEGS; s++) begin
            prod = longint'(slot_length) * cfg_global * level_mem[dig][s] / 10000;
            if (prod > slot_length) prod = slot_length;
            thresh[s] = prod[15:0];
         end
      end
      f.segment_lines = 7'h7F;
      for (int s = 0; s < ssmpf_pkg::SEGS; s++)
         if (slot_cnt < thresh[s]) f.segment_lines[s] = 1'b0;
      f.digit_enable = 6'(1 << dig);
      expected_frames.push_back(f);
      slot_cnt = slot_cnt + 16'd1;
      if (slot_cnt >= slot_length) begin
         slot_cnt = '0;
         cur_digit = (dig + 1 >= NDIG) ? 3'd0 : 3'(dig + 1);
      end
   endtask

   function automatic cmd_item_type make_tick();
      cmd_item_type it;
      it.mode = ssmpf_pkg::MODE_TICK;
      it.position = 3'($urandom_range(0, 7));
      it.char_code = 8'($urandom);
      it.raw_mask = 8'($urandom);
      return it;
   endfunction

   function automatic cmd_item_type make_set(input logic [1:0] m, input logic [2:0] p,
                                             input logic [7:0] ch, input logic [7:0] rm);
      cmd_item_type it;
      it.mode = m;
      it.position = p;
      it.char_code = ch;
      it.raw_mask = rm;
      return it;
   endfunction

   // Random item: mostly ticks so the fade and PWM go deep, with set commands
   // mixed in to keep the targets moving.
   function automatic cmd_item_type make_random();
      int r;
      string glyphs;
      glyphs = "0123456789AbcdEfghIJLnoPqrStuY-_ Kz";
      r = $urandom_range(0, 99);
      if (r < 75) return make_tick();
      if (r < 87) return make_set(ssmpf_pkg::MODE_CHAR, 3'($urandom_range(0, 7)),
                                  ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                  glyphs[$urandom_range(0, glyphs.len() - 1)],
                                  8'($urandom));
      if (r < 98) return make_set(ssmpf_pkg::MODE_RAW, 3'($urandom_range(0, 7)),
                                  8'($urandom), 8'($urandom));
      return make_set(2'd3, 3'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   // Register write from the stimulus thread; called only while idle.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      predict_csr(idx, val);
   endtask

   task automatic wait_idle();
      wait (pending_cmds.size() == 0 && expected_frames.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) pending_cmds.push_back(make_random());
   endtask

   // Driver: sends in bursts with gaps, changing inputs on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_mode <= '0;
         req_position <= '0;
         req_char_code <= '0;
         req_raw_mask <= '0;
         rsp_pop <= 1'b0;
      end else begin
         if (req_push && !req_full_q) begin
            void'(pending_cmds.pop_front());
            if (burst_left > 0) burst_left--;
         end
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         end
         if (gap_left > 0 && burst_left > 0 && !(req_push && !req_full_q)) gap_left--;
         if (pending_cmds.size() > 0 && !hold_sender && gap_left == 0) begin
            req_push <= 1'b1;
            req_mode <= pending_cmds[0].mode;
            req_position <= pending_cmds[0].position;
            req_char_code <= pending_cmds[0].char_code;
            req_raw_mask <= pending_cmds[0].raw_mask;
         end else begin
            req_push <= 1'b0;
         end
         // Receiver stall pattern: long free runs alternate with choppy stretches.
         pop_phase = (pop_phase + 1) % 997;
         if (pop_phase < 300) rsp_pop <= 1'b1;
         else if (pop_phase < 700) rsp_pop <= ($urandom_range(0, 3) != 0);
         else rsp_pop <= ($urandom_range(0, 4) == 0);
      end
   end

   // Monitor: samples both handshakes at the rising edge, predicts on input
   // transfers and checks output transfers against the oldest expected frame.
   always @(posedge clock) begin
      frame_type exp_f;
      req_full_q <= req_full;
      if (reset) begin
         watchdog <= 0;
      end else begin
         if (req_push && !req_full) begin
            predict_item(make_set(req_mode, req_position, req_char_code, req_raw_mask));
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_frames.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected frame seg=%h dig=%h",
                           rsp_segment_lines, rsp_digit_enable);
            end else begin
               exp_f = expected_frames.pop_front();
               if (exp_f.segment_lines !== rsp_segment_lines ||
                   exp_f.digit_enable !== rsp_digit_enable) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: frame seg exp=%h act=%h dig exp=%h act=%h",
                              exp_f.segment_lines, rsp_segment_lines,
                              exp_f.digit_enable, rsp_digit_enable);
               end
            end
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (pending_cmds.size() == 0 && expected_frames.size() == 0))
            watchdog <= 0;
         else
            watchdog <= watchdog + 1;
         if (watchdog >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
   end

   // Timeout ends the run as a failure.
   always @(posedge clock) begin
      if (timed_out && !stim_done) begin
         $display("tb_seven_segment_mux_pwm_fader_unit: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      stim_done = 1'b0;
      hold_sender = 1'b0;
      predictor_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Short slots and fast fades so the directed part sees real dimming.
      write_csr(ssmpf_pkg::REG_PERIOD, 16'd3);
      write_csr(ssmpf_pkg::REG_FADE_INT, 16'd1);
      write_csr(ssmpf_pkg::REG_FADE_LVL, 16'd0);
      write_csr(ssmpf_pkg::REG_GLOBAL, 16'd100);

      // Directed: glyph extremes, lower case, unknown character, raw extremes,
      // out-of-range position and the unused mode.
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_CHAR, 3'd0, "8", 8'h00));
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_CHAR, 3'd1, "a", 8'hFF));
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_CHAR, 3'd2, 8'hFF, 8'h00));
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_CHAR, 3'd3, "K", 8'h00));
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_RAW, 3'd4, 8'hFF, 8'h00));
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_RAW, 3'd5, 8'h00, 8'h80));
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_RAW, 3'd6, 8'h00, 8'h00));
      pending_cmds.push_back(make_set(ssmpf_pkg::MODE_CHAR, 3'd7, "0", 8'hFF));
      pending_cmds.push_back(make_set(2'd3, 3'd0, 8'hFF, 8'hFF));
      for (int i = 0; i < 16; i++) pending_cmds.push_back(make_tick());

      // The sender waits here until every expected frame has arrived.
      wait_idle();

      // Fade interval raised, fade level above its maximum, global level zero.
      write_csr(ssmpf_pkg::REG_FADE_INT, 16'd500);
      write_csr(ssmpf_pkg::REG_FADE_LVL, 16'd15);
      write_csr(ssmpf_pkg::REG_GLOBAL, 16'd0);
      for (int i = 0; i < 20; i++) pending_cmds.push_back(make_tick());
      wait_idle();
      write_csr(ssmpf_pkg::REG_FADE_INT, 16'd2);
      write_csr(ssmpf_pkg::REG_PERIOD, 16'd0);
      write_csr(ssmpf_pkg::REG_GLOBAL, 16'd127);
      run_random(400);
      wait_idle();

      write_csr(ssmpf_pkg::REG_PERIOD, 16'd7);
      write_csr(ssmpf_pkg::REG_FADE_INT, 16'd0);
      write_csr(ssmpf_pkg::REG_FADE_LVL, 16'd1);
      write_csr(ssmpf_pkg::REG_GLOBAL, 16'd37);
      run_random(400);
      wait_idle();

      write_csr(ssmpf_pkg::REG_PERIOD, 16'hFFFF);
      write_csr(ssmpf_pkg::REG_FADE_INT, 16'hFFFF);
      write_csr(ssmpf_pkg::REG_FADE_LVL, 16'd10);
      write_csr(ssmpf_pkg::REG_GLOBAL, 16'd1);
      run_random(200);
      wait_idle();

      write_csr(ssmpf_pkg::REG_PERIOD, 16'd12);
      write_csr(ssmpf_pkg::REG_FADE_INT, 16'd3);
      write_csr(ssmpf_pkg::REG_FADE_LVL, 16'd7);
      write_csr(ssmpf_pkg::REG_GLOBAL, 16'd80);
      run_random(625);
      wait_idle();

      stim_done = 1'b1;
      if (mismatches == 0 && !timed_out)
         $display("tb_seven_segment_mux_pwm_fader_unit: PASS");
      else
         $display("tb_seven_segment_mux_pwm_fader_unit: FAIL");
      $finish;
   end

endmodule
